### rtl/tncd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker note cell decoder package
// Shared request/result types, table entry layouts, FSM states and constants.
// ----------------------------------------------------------------------------
package tncd_pkg;

    // Opcodes carried in the request
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NOTE = 1'b1;

    localparam int PERIOD_W   = 12;
    localparam int DIVIDEND_W = 18;
    localparam logic [DIVIDEND_W-1:0] CLOCK_CONST = 18'd187815;
    localparam logic [7:0] NO_EFFECT = 8'hFF;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  channel_index;
        logic        channel_enabled;
        logic [7:0]  cell_byte_zero;
        logic [7:0]  cell_byte_one;
        logic [7:0]  cell_byte_two;
        logic [7:0]  cell_byte_three;
        logic [4:0]  slot_number;
        logic [6:0]  slot_default_volume;
        logic [15:0] slot_loop_start;
    } request_t;

    typedef struct packed {
        logic        play_now;
        logic [4:0]  play_sample_id;
        logic [2:0]  play_chan;
        logic [7:0]  play_volume;
        logic        play_looped;
        logic [15:0] play_frequency;
        logic [7:0]  decoded_sample;
        logic [11:0] decoded_period;
        logic [7:0]  channel_effect;
        logic [7:0]  channel_effect_param;
    } result_t;

    // One entry of the per-channel table
    typedef struct packed {
        logic [4:0] smp_latch;
        logic [7:0] vol_latch;
        logic [7:0] vol_live;
        logic [7:0] effect;
        logic [7:0] fx_param;
    } chan_entry_t;

    // One entry of the sample slot table
    typedef struct packed {
        logic [6:0] volume;
        logic       looped;
    } slot_entry_t;

    localparam int CHAN_W = $bits(chan_entry_t);
    localparam int SLOT_W = $bits(slot_entry_t);

    localparam chan_entry_t CHAN_RESET = '{
        smp_latch: 5'd0,
        vol_latch: 8'd0,
        vol_live:  8'd0,
        effect:    NO_EFFECT,
        fx_param:  8'd0
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHAN,
        ST_SLOT,
        ST_WAIT
    } state_t;

endpackage

### rtl/tncd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tncd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tncd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequency divider
// Restoring division of the fixed clock constant by a 12-bit period,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tncd_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [tncd_pkg::PERIOD_W-1:0]       divisor,
    output logic                                busy,
    output logic                                done,
    output logic [tncd_pkg::DIVIDEND_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(tncd_pkg::DIVIDEND_W + 1);

    logic                               run_reg,  run_next;
    logic                               done_reg, done_next;
    logic [CNT_W-1:0]                   cnt_reg,  cnt_next;
    logic [tncd_pkg::PERIOD_W-1:0]      dvs_reg,  dvs_next;
    logic [tncd_pkg::PERIOD_W-1:0]      rem_reg,  rem_next;
    logic [tncd_pkg::DIVIDEND_W-1:0]    dvd_reg,  dvd_next;
    logic [tncd_pkg::DIVIDEND_W-1:0]    quo_reg,  quo_next;
    logic [tncd_pkg::PERIOD_W:0]        trial;
    logic                               fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        // shift the next dividend bit into the partial remainder
        trial     = {rem_reg, dvd_reg[tncd_pkg::DIVIDEND_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(tncd_pkg::DIVIDEND_W);
            dvs_next = divisor;
            rem_next = '0;
            dvd_next = tncd_pkg::CLOCK_CONST;
            quo_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = fits ? tncd_pkg::PERIOD_W'(trial - {1'b0, dvs_reg})
                            : tncd_pkg::PERIOD_W'(trial);
            dvd_next = {dvd_reg[tncd_pkg::DIVIDEND_W-2:0], 1'b0};
            quo_next = {quo_reg[tncd_pkg::DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign busy     = run_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/tracker_note_cell_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker note cell decoder
// Loads sample slots and decodes four-byte tracker note cells into play
// requests with volume, loop flag and playback frequency.
// ----------------------------------------------------------------------------
// Flow: the accepting edge takes the request and starts the divide; a note
//   then reads the channel and slot tables while the divider runs.
// A new request is taken only after the result: busy stays high until the
//   result strobe, while the restoring divider computes 187815/period.
// Results are shown on result for one cycle with done; the receiver cannot
//   stall, so nothing waits on the output side.
// Reset clears the FSM and the per-entry valid bits; an entry never written
//   reads as its reset value, so no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module tracker_note_cell_decoder #(
    parameter int NUM_CHANNELS = 8,
    parameter int NUM_SLOTS    = 31
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tncd_pkg::request_t request,
    output logic               done,
    output tncd_pkg::result_t  result
);

    localparam int CH_AW = $clog2(NUM_CHANNELS);
    localparam int SL_AW = $clog2(NUM_SLOTS);

    // Control state
    tncd_pkg::state_t        state_reg, state_next;
    logic [NUM_SLOTS-1:0]    slot_valid_reg, slot_valid_next;
    logic [NUM_CHANNELS-1:0] chan_valid_reg, chan_valid_next;
    logic                    done_reg, done_next;

    // Datapath holding registers
    tncd_pkg::request_t      req_reg, req_next;
    tncd_pkg::chan_entry_t   chan_cur_reg, chan_cur_next;
    tncd_pkg::result_t       hold_reg, hold_next;
    tncd_pkg::result_t       result_reg, result_next;
    logic                    chan_vld_rd_reg, chan_vld_rd_next;
    logic                    slot_vld_rd_reg, slot_vld_rd_next;

    // Memory ports
    logic                        chan_we;
    logic [CH_AW-1:0]            chan_waddr, chan_raddr;
    tncd_pkg::chan_entry_t       chan_wdata;
    logic [tncd_pkg::CHAN_W-1:0] chan_rdata;
    logic                        slot_we;
    logic [SL_AW-1:0]            slot_waddr, slot_raddr;
    tncd_pkg::slot_entry_t       slot_wdata;
    logic [tncd_pkg::SLOT_W-1:0] slot_rdata;

    // Divider
    logic                              div_start;
    logic                              div_busy;
    logic                              div_done;
    logic [tncd_pkg::DIVIDEND_W-1:0]   div_quo;

    // Decode of the held request
    logic [7:0]              sample;
    logic [11:0]             period;
    logic [3:0]              effect;
    logic [CH_AW-1:0]        ch;
    logic                    ch_ok;
    logic                    known;
    logic                    load_ok;
    logic                    ls_ok;
    tncd_pkg::chan_entry_t   chan_rd;
    tncd_pkg::chan_entry_t   chan_new;
    tncd_pkg::slot_entry_t   slot_rd;
    logic [15:0]             freq;

    tncd_ram #(
        .WIDTH (tncd_pkg::CHAN_W),
        .DEPTH (NUM_CHANNELS)
    ) u_chan_ram (
        .clk   (clk),
        .we    (chan_we),
        .waddr (chan_waddr),
        .wdata (chan_wdata),
        .raddr (chan_raddr),
        .rdata (chan_rdata)
    );

    tncd_ram #(
        .WIDTH (tncd_pkg::SLOT_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    tncd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (request.cell_byte_zero[3:0] == 4'd0 && request.cell_byte_one == 8'd0
                   ? 12'd1 : {request.cell_byte_zero[3:0], request.cell_byte_one}),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tncd_pkg::ST_IDLE;
            slot_valid_reg <= '0;
            chan_valid_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            chan_valid_reg <= chan_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        chan_cur_reg    <= chan_cur_next;
        hold_reg        <= hold_next;
        result_reg      <= result_next;
        chan_vld_rd_reg <= chan_vld_rd_next;
        slot_vld_rd_reg <= slot_vld_rd_next;
    end

    // Field decode of the held cell; sample is a plain nibble join
    assign sample  = {req_reg.cell_byte_zero[7:4], req_reg.cell_byte_two[7:4]};
    assign period  = {req_reg.cell_byte_zero[3:0], req_reg.cell_byte_one};
    assign effect  = req_reg.cell_byte_two[3:0];
    assign ch      = req_reg.channel_index[CH_AW-1:0];
    assign ch_ok   = {1'b0, req_reg.channel_index} < 4'(NUM_CHANNELS);
    assign known   = req_reg.channel_enabled && sample != 8'd0
                     && sample <= 8'(NUM_SLOTS);
    assign load_ok = request.slot_number != 5'd0
                     && {1'b0, request.slot_number} <= 6'(NUM_SLOTS);

    // Entries never written read as their reset value
    assign chan_rd = chan_vld_rd_reg ? tncd_pkg::chan_entry_t'(chan_rdata)
                                     : tncd_pkg::CHAN_RESET;
    assign slot_rd = slot_vld_rd_reg ? tncd_pkg::slot_entry_t'(slot_rdata)
                                     : '0;

    // Saturate the 18-bit quotient; zero period gives zero
    assign freq = (period == 12'd0) ? 16'd0
                : (div_quo[tncd_pkg::DIVIDEND_W-1:16] != '0) ? 16'hFFFF
                : div_quo[15:0];

    always_comb
    begin
        state_next       = state_reg;
        slot_valid_next  = slot_valid_reg;
        chan_valid_next  = chan_valid_reg;
        done_next        = 1'b0;
        req_next         = req_reg;
        chan_cur_next    = chan_cur_reg;
        hold_next        = hold_reg;
        result_next      = result_reg;
        chan_vld_rd_next = chan_vld_rd_reg;
        slot_vld_rd_next = slot_vld_rd_reg;
        chan_we          = 1'b0;
        chan_waddr       = ch;
        chan_wdata       = chan_cur_reg;
        chan_raddr       = request.channel_index[CH_AW-1:0];
        slot_we          = 1'b0;
        slot_waddr       = SL_AW'(request.slot_number - 5'd1);
        slot_wdata       = '{volume: request.slot_default_volume,
                             looped: request.slot_loop_start != 16'd0};
        slot_raddr       = SL_AW'(sample[4:0] - 5'd1);
        div_start        = 1'b0;
        chan_new         = chan_cur_reg;
        ls_ok            = 1'b0;

        unique case (state_reg)
            tncd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    // take the request, start the divide, issue the channel read; a valid load also writes its slot
                    req_next         = request;
                    hold_next        = '0;
                    div_start        = 1'b1;
                    chan_vld_rd_next = chan_valid_reg[request.channel_index[CH_AW-1:0]];
                    if (request.opcode == tncd_pkg::OP_LOAD)
                    begin
                        if (load_ok)
                        begin
                            slot_we                     = 1'b1;
                            slot_valid_next[slot_waddr] = 1'b1;
                        end
                        state_next = tncd_pkg::ST_WAIT;
                    end
                    else
                    begin
                        state_next = tncd_pkg::ST_CHAN;
                    end
                end
            end

            tncd_pkg::ST_CHAN:
            begin
                // hold channel entry; read the slot of the new or latched sample
                chan_cur_next = chan_rd;
                if (!known)
                begin
                    slot_raddr = SL_AW'(chan_rd.smp_latch - 5'd1);
                end
                slot_vld_rd_next = slot_valid_reg[slot_raddr];
                state_next       = tncd_pkg::ST_SLOT;
            end

            tncd_pkg::ST_SLOT:
            begin
                // modify the channel entry, write it back for an in-range channel, build the held result
                if (effect != 4'd0)
                begin
                    chan_new.effect   = {4'd0, effect};
                    chan_new.fx_param = req_reg.cell_byte_three;
                end
                if (known)
                begin
                    chan_new.smp_latch = sample[4:0];
                    chan_new.vol_latch = {slot_rd.volume, 1'b0} - 8'd1;
                end
                ls_ok = chan_new.smp_latch != 5'd0
                        && {1'b0, chan_new.smp_latch} <= 6'(NUM_SLOTS);
                hold_next.play_chan      = req_reg.channel_index;
                hold_next.decoded_sample = sample;
                hold_next.decoded_period = period;
                hold_next.channel_effect = tncd_pkg::NO_EFFECT;
                if (ch_ok)
                begin
                    if (req_reg.channel_enabled && period != 12'd0 && ls_ok)
                    begin
                        chan_new.vol_live        = chan_new.vol_latch;
                        hold_next.play_now       = 1'b1;
                        hold_next.play_sample_id = chan_new.smp_latch;
                        hold_next.play_volume    = chan_new.vol_latch;
                        hold_next.play_looped    = slot_rd.looped;
                    end
                    hold_next.channel_effect       = chan_new.effect;
                    hold_next.channel_effect_param = chan_new.fx_param;
                    chan_we             = 1'b1;
                    chan_wdata          = chan_new;
                    chan_valid_next[ch] = 1'b1;
                end
                state_next = tncd_pkg::ST_WAIT;
            end

            tncd_pkg::ST_WAIT:
            begin
                // drive the result once the divider finishes
                if (div_done)
                begin
                    result_next = hold_reg;
                    if (req_reg.opcode == tncd_pkg::OP_NOTE)
                    begin
                        result_next.play_frequency = freq;
                    end
                    done_next  = 1'b1;
                    state_next = tncd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tncd_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = state_reg != tncd_pkg::ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    // The divider must never finish before the FSM waits for it
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == tncd_pkg::ST_WAIT)
        else $error("divider finished outside the wait state");

    // A finished divide always produces a result strobe next cycle
    a_done_follows_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tncd_pkg::ST_WAIT && div_done |=> done_reg)
        else $error("result strobe missing after divide");

    // Divider is idle whenever the block can take a request
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tncd_pkg::ST_IDLE |-> !div_busy)
        else $error("divider busy while block idle");

    // A play result always names a real slot
    a_play_slot: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.play_now |-> result_reg.play_sample_id != 5'd0)
        else $error("play result with slot zero");

endmodule

### tb/sv/tb_tracker_note_cell_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker note cell decoder testbench
// Drives slot loads and note cells through the start/busy command port and
// checks every done strobe field by field against a behavioral predictor of
// the slot table and the per-channel latches. A directed pass covers the
// field extremes and the corner cases; random passes then run with light,
// heavy and no idling on the request side.
// ----------------------------------------------------------------------------
module tb_tracker_note_cell_decoder;

    import tncd_pkg::*;

    localparam int NUM_CHANNELS = 8;
    localparam int NUM_SLOTS    = 31;
    // Dividend of the period-to-frequency conversion
    localparam int unsigned PERIOD_CLOCK = 187815;
    // Decode time of one request, used to size idle gaps and the drain wait
    localparam int LATENCY = 20;
    localparam int MAX_PRINTED = 40;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;

    tracker_note_cell_decoder #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_SLOTS    (NUM_SLOTS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: slot table and per-channel latches
    // ------------------------------------------------------------------------
    logic [6:0] slot_volume  [1:NUM_SLOTS];
    logic       slot_looped  [1:NUM_SLOTS];
    logic [4:0] chan_sample  [0:NUM_CHANNELS-1];
    logic [7:0] chan_volume  [0:NUM_CHANNELS-1];
    logic [7:0] chan_effect  [0:NUM_CHANNELS-1];
    logic [7:0] chan_param   [0:NUM_CHANNELS-1];

    result_t expected_results[$];

    int mismatch_count;
    int sender_idle_pct;
    int loads_sent;
    int notes_sent;
    int results_checked;
    int plays_checked;

    // Bring the predictor to its post-reset state
    task automatic clear_predictor();
        for (int s = 1; s <= NUM_SLOTS; s++)
        begin
            slot_volume[s] = '0;
            slot_looped[s] = 1'b0;
        end
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            chan_sample[c] = '0;
            chan_volume[c] = '0;
            chan_effect[c] = NO_EFFECT;
            chan_param[c]  = '0;
        end
    endtask

    // Update the predictor with one accepted request and return its result
    function automatic result_t predict_decode(input request_t r);
        result_t     res;
        logic [7:0]  smp;
        logic [11:0] per;
        logic [3:0]  eff;
        logic [2:0]  ch;
        int unsigned quo;
        res = '0;
        if (r.opcode == OP_LOAD)
        begin
            // Slot zero is not a slot: drop the write
            if (r.slot_number >= 1 && r.slot_number <= NUM_SLOTS)
            begin
                slot_volume[r.slot_number] = r.slot_default_volume;
                slot_looped[r.slot_number] = (r.slot_loop_start != 16'd0);
            end
            return res;
        end
        // Sample is high nibble of byte zero over high nibble of byte two
        smp = {r.cell_byte_zero[7:4], r.cell_byte_two[7:4]};
        per = {r.cell_byte_zero[3:0], r.cell_byte_one};
        eff = r.cell_byte_two[3:0];
        ch  = r.channel_index;
        // Every 3-bit channel index is a real channel with NUM_CHANNELS = 8
        if (eff != 4'd0)
        begin
            chan_effect[ch] = {4'd0, eff};
            chan_param[ch]  = r.cell_byte_three;
        end
        if (r.channel_enabled)
        begin
            // Sample numbers 0 and above NUM_SLOTS leave the latch alone
            if (smp >= 1 && smp <= NUM_SLOTS)
            begin
                chan_sample[ch] = smp[4:0];
                chan_volume[ch] = {slot_volume[smp[4:0]], 1'b0} - 8'd1;
            end
            if (per != 12'd0 && chan_sample[ch] != 5'd0)
            begin
                res.play_now       = 1'b1;
                res.play_sample_id = chan_sample[ch];
                res.play_volume    = chan_volume[ch];
                res.play_looped    = slot_looped[chan_sample[ch]];
            end
        end
        if (per != 12'd0)
        begin
            quo = PERIOD_CLOCK / per;
            res.play_frequency = (quo > 32'hFFFF) ? 16'hFFFF : quo[15:0];
        end
        res.play_chan            = ch;
        res.decoded_sample       = smp;
        res.decoded_period       = per;
        res.channel_effect       = chan_effect[ch];
        res.channel_effect_param = chan_param[ch];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    // Match each strobed result against the oldest pending expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result strobe with no request pending");
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.play_now)
                    plays_checked++;
                check_field("play_now", 32'(result.play_now), 32'(want.play_now));
                check_field("play_sample_id", 32'(result.play_sample_id),
                            32'(want.play_sample_id));
                check_field("play_chan", 32'(result.play_chan), 32'(want.play_chan));
                check_field("play_volume", 32'(result.play_volume), 32'(want.play_volume));
                check_field("play_looped", 32'(result.play_looped), 32'(want.play_looped));
                check_field("play_frequency", 32'(result.play_frequency),
                            32'(want.play_frequency));
                check_field("decoded_sample", 32'(result.decoded_sample),
                            32'(want.decoded_sample));
                check_field("decoded_period", 32'(result.decoded_period),
                            32'(want.decoded_period));
                check_field("channel_effect", 32'(result.channel_effect),
                            32'(want.channel_effect));
                check_field("channel_effect_param", 32'(result.channel_effect_param),
                            32'(want.channel_effect_param));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request construction
    // ------------------------------------------------------------------------
    function automatic request_t make_load(input logic [4:0] slot, input logic [6:0] vol,
                                           input logic [15:0] loop_words);
        request_t r;
        r = '0;
        r.opcode              = OP_LOAD;
        r.slot_number         = slot;
        r.slot_default_volume = vol;
        r.slot_loop_start     = loop_words;
        return r;
    endfunction

    function automatic request_t make_note(input logic [2:0] ch, input logic en,
                                           input logic [7:0] smp, input logic [11:0] per,
                                           input logic [3:0] eff, input logic [7:0] param);
        request_t r;
        r = '0;
        r.opcode          = OP_NOTE;
        r.channel_index   = ch;
        r.channel_enabled = en;
        r.cell_byte_zero  = {smp[7:4], per[11:8]};
        r.cell_byte_one   = per[7:0];
        r.cell_byte_two   = {smp[3:0], eff};
        r.cell_byte_three = param;
        return r;
    endfunction

    // Mostly well-formed loads and cells, some raw noise
    function automatic request_t random_request();
        request_t    r;
        logic [7:0]  smp;
        logic [11:0] per;
        int unsigned pick;
        // Fill every field first so unused ones toggle too
        r.opcode              = OP_NOTE;
        r.channel_index       = 3'($urandom);
        r.channel_enabled     = ($urandom_range(99) < 85);
        r.cell_byte_zero      = 8'($urandom);
        r.cell_byte_one       = 8'($urandom);
        r.cell_byte_two       = 8'($urandom);
        r.cell_byte_three     = 8'($urandom);
        r.slot_number         = 5'($urandom);
        r.slot_default_volume = 7'($urandom);
        r.slot_loop_start     = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 18)
        begin
            r.opcode = OP_LOAD;
            if ($urandom_range(15) != 0)
                r.slot_number = 5'($urandom_range(NUM_SLOTS, 1));
            if ($urandom_range(3) != 0)
                r.slot_default_volume = 7'($urandom_range(64));
            if ($urandom_range(1) == 0)
                r.slot_loop_start = '0;
        end
        else if (pick >= 28)
        begin
            // Well-formed cell: mostly a known or absent sample and a musical period
            case ($urandom_range(9))
                0, 1, 2, 3: smp = 8'd0;
                9:          smp = 8'($urandom);
                default:    smp = 8'($urandom_range(NUM_SLOTS, 1));
            endcase
            case ($urandom_range(19))
                0, 1:    per = 12'd0;
                2:       per = 12'($urandom_range(3, 1));
                3, 4:    per = 12'($urandom);
                default: per = 12'($urandom_range(907, 108));
            endcase
            r.cell_byte_zero = {smp[7:4], per[11:8]};
            r.cell_byte_one  = per[7:0];
            r.cell_byte_two  = {smp[3:0], r.cell_byte_two[3:0]};
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Send one request: idle a random while, then hold start until accepted
    // ------------------------------------------------------------------------
    task automatic send_request(input request_t r);
        int idle;
        idle = 0;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
            idle++;
        // Now and then stretch the gap past the whole decode so the next
        // request lands in every phase, idle block included
        if (sender_idle_pct != 0 && $urandom_range(7) == 0)
            idle += $urandom_range(LATENCY + 10);
        if (idle > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (idle - 1) @(negedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= r;
        // Advance until an edge with busy low takes the request
        do
            @(posedge clk);
        while (busy !== 1'b0);
        expected_results.push_back(predict_decode(r));
        if (r.opcode == OP_LOAD)
            loads_sent++;
        else
            notes_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Slot table extremes, including a load to slot zero that must be dropped
    task automatic test_slot_loads();
        send_request(make_load(5'd1, 7'd64, 16'd0));
        send_request(make_load(5'd31, 7'd0, 16'hFFFF));
        send_request(make_load(5'd0, 7'd127, 16'd1));
        send_request(make_load(5'd16, 7'd127, 16'h8000));
        send_request(make_load(5'd2, 7'd1, 16'd1));
    endtask

    // Cell decoding corners: saturation, unknown samples, disabled channels,
    // effect latching and replay of a latched sample
    task automatic test_note_cells();
        // Plain note on slot one, no effect
        send_request(make_note(3'd0, 1'b1, 8'd1, 12'd428, 4'h0, 8'h00));
        // Period one saturates; slot 31 has volume zero, wrapping to 255
        send_request(make_note(3'd7, 1'b1, 8'd31, 12'd1, 4'hF, 8'hFF));
        // Nothing latched yet on channel 3: no play even with a period
        send_request(make_note(3'd3, 1'b1, 8'd0, 12'd2, 4'h1, 8'h01));
        // Slot 16 volume 127 gives 253 (doubled, less one)
        send_request(make_note(3'd3, 1'b1, 8'd16, 12'd3, 4'h0, 8'h55));
        // Disabled channel latches only its effect
        send_request(make_note(3'd5, 1'b0, 8'd2, 12'd100, 4'hC, 8'h40));
        send_request(make_note(3'd5, 1'b1, 8'd0, 12'hFFF, 4'h0, 8'hAA));
        // Replay the latched sample on channel 0 with no sample in the cell
        send_request(make_note(3'd0, 1'b1, 8'd0, 12'd200, 4'h0, 8'h77));
        // Unknown samples still show the raw decoded value
        send_request(make_note(3'd1, 1'b1, 8'hFF, 12'd0, 4'h3, 8'h12));
        send_request(make_note(3'd4, 1'b1, 8'd32, 12'd500, 4'h0, 8'h00));
        send_request(make_note(3'd2, 1'b1, 8'hFF, 12'hFFF, 4'hF, 8'hFF));
        send_request(make_note(3'd6, 1'b0, 8'd0, 12'd0, 4'h0, 8'h00));
        // Zero effect keeps the old latch despite a new parameter
        send_request(make_note(3'd7, 1'b1, 8'd0, 12'd856, 4'h0, 8'h99));
        // Reload a playing slot, then hit it again: new volume and loop flag
        send_request(make_load(5'd1, 7'd33, 16'h0100));
        send_request(make_note(3'd0, 1'b1, 8'd1, 12'd113, 4'h8, 8'h80));
        // Disabled channel with a period keeps quiet but still gives frequency
        send_request(make_note(3'd0, 1'b0, 8'd2, 12'd254, 4'h0, 8'h00));
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct);
        sender_idle_pct = idle_pct;
        repeat (count)
            send_request(random_request());
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int waited;
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        request         = '0;
        mismatch_count  = 0;
        loads_sent      = 0;
        notes_sent      = 0;
        results_checked = 0;
        plays_checked   = 0;
        sender_idle_pct = 12;
        clear_predictor();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_slot_loads();
        test_note_cells();
        test_random_traffic(220, 12);
        test_random_traffic(220, 79);
        test_random_traffic(210, 0);

        @(negedge clk);
        start <= 1'b0;

        // Drain: wait for every pending result, then watch for strays
        waited = 0;
        while (expected_results.size() != 0 && waited < 50 * LATENCY)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2 * LATENCY) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("Covered %0d slot loads and %0d note cells; %0d results checked, %0d played.",
                 loads_sent, notes_sent, results_checked, plays_checked);
        $display("Request idling went 12%%, 79%%, then none; %0d mismatches.", mismatch_count);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hang guard: far beyond the slowest correct run
    initial
    begin
        #1_000_000;
        $display("Timeout with %0d results pending.", expected_results.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
